>>> src/pdac_pkg.sv
package pdac_pkg;

   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned POS_W    = 32;
   localparam int unsigned ERR_W    = 33;
   localparam int unsigned DT_W     = 16;
   localparam int unsigned OPA_W    = 17;
   localparam int unsigned OPB_W    = 34;
   localparam int unsigned PROD_W   = OPA_W + OPB_W;
   localparam int unsigned ACC_W    = 66;
   localparam int unsigned INTEG_W  = 48;
   localparam int unsigned HALF_W   = 24;
   localparam int unsigned CMD_W    = 26;
   localparam int unsigned REG_W    = 48;
   localparam int unsigned AXIS_W   = 2;
   localparam int unsigned CSR_IDX_W = 3;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_KP    = 3'd0;
   localparam csr_index_type REG_KI    = 3'd1;
   localparam csr_index_type REG_KD    = 3'd2;
   localparam csr_index_type REG_LIMIT = 3'd3;

   localparam logic [REG_W-1:0] LIMIT_RESET = 48'h0100_0100_0100;

   localparam logic MODE_PID = 1'b0;
   localparam logic MODE_PD  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROP,
      ST_DERIV,
      ST_CLAMP,
      ST_INTEG,
      ST_ACCUM,
      ST_KI_LO,
      ST_KI_HI,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic enable;
      logic clear;
      logic shift_hi;
   } mac_ctrl_type;

   // Picks the Q8.8 value of one axis out of a packed register; axis 3 reads zero.
   function automatic logic [GAIN_W-1:0] axis_field(input logic [REG_W-1:0] reg_value,
                                                    input logic [AXIS_W-1:0] axis);
      logic [GAIN_W-1:0] field;
      unique case (axis)
         2'd0: field = reg_value[15:0];
         2'd1: field = reg_value[31:16];
         2'd2: field = reg_value[47:32];
         default: field = '0;
      endcase
      return field;
   endfunction

endpackage

>>> src/pdac_mac.sv
module pdac_mac
   import pdac_pkg::*;
(
   input  logic                     clock,
   input  mac_ctrl_type             ctrl,
   input  logic signed [OPA_W-1:0]  op_a,
   input  logic signed [OPB_W-1:0]  op_b,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   assign prod     = PROD_W'(op_a) * PROD_W'(op_b);
   assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
   // The upper half of a wide operand is weighted by two to the HALF_W.
   assign addend   = ctrl.shift_hi ? (prod_ext <<< HALF_W) : prod_ext;
   assign base     = ctrl.clear ? '0 : acc_ff;
   assign acc_in   = base + addend;

   always_ff @(posedge clock) begin
      if (ctrl.enable) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

>>> src/position_pid_accel_command_top.sv
// Three-axis position controller: each accepted word carries one axis and yields one
// acceleration command word, kp*ep + kd*ed clamped to the axis limit, plus ki times
// the per-axis integral in PID mode. All products run through a single shared
// 17x34-bit multiply-accumulate unit, one product per cycle, so the block takes one
// word at a time: a PD word, or a PID word whose axis I gain is zero, steps through
// PROP, DERIV, CLAMP and OUT; a PID word with a nonzero I gain adds INTEG, ACCUM,
// KI_LO, KI_HI and SUM (the 48-bit integral times ki is done as two partial products);
// a word for an axis at or beyond AXES goes to OUT and returns zero. A finished command sits
// in an output register, so the next word is taken while it waits; the block only
// holds longer when a new command is ready while the previous one is still stalled
// on the result side. Configuration writes are always accepted and belong in idle
// periods.
module position_pid_accel_command_top
   import pdac_pkg::*;
#(
   parameter int AXES = 3
)
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_mode,
   input  logic [AXIS_W-1:0]         req_axis,
   input  logic signed [POS_W-1:0]   req_current_position,
   input  logic signed [POS_W-1:0]   req_current_velocity,
   input  logic signed [POS_W-1:0]   req_target_position,
   input  logic signed [POS_W-1:0]   req_target_velocity,
   input  logic [DT_W-1:0]           req_time_step,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [AXIS_W-1:0]         rsp_out_axis,
   output logic signed [POS_W-1:0]   rsp_accel_command,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  csr_index_type             csr_index,
   input  logic [REG_W-1:0]          csr_data
);

   localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

   state_type state_ff, state_in;

   logic [REG_W-1:0] kp_ff, ki_ff, kd_ff, limit_ff;

   logic                     mode_ff;
   logic [AXIS_W-1:0]        axis_ff;
   logic signed [ERR_W-1:0]  ep_ff;
   logic signed [ERR_W-1:0]  ed_ff;
   logic [DT_W-1:0]          dt_ff;
   logic signed [CMD_W-1:0]  cmd_ff;
   logic signed [POS_W-1:0]  res_ff;

   logic signed [INTEG_W-1:0] integ_ff [AXES];
   logic signed [INTEG_W-1:0] integ_in;
   logic                      integ_we;
   logic signed [INTEG_W-1:0] integ_rd;
   logic [IDX_W-1:0]          integ_idx;

   logic                      rsp_valid_ff;
   logic [AXIS_W-1:0]         rsp_axis_ff;
   logic signed [POS_W-1:0]   rsp_cmd_ff;

   logic                      req_take;
   logic                      req_axis_ok;
   logic                      out_load;
   logic [GAIN_W-1:0]         kp_sel, ki_sel, kd_sel, lim_sel;

   mac_ctrl_type              mac_ctrl;
   logic signed [OPA_W-1:0]   op_a;
   logic signed [OPB_W-1:0]   op_b;
   logic signed [ACC_W-1:0]   acc;

   logic signed [ACC_W-1:0]   lim_pos, lim_neg, pd_clamped;
   logic signed [OPB_W-1:0]   integ_inc;
   logic signed [INTEG_W+1:0] integ_sum;
   logic signed [INTEG_W-1:0] integ_sat;
   logic signed [ACC_W-8:0]   cmd_total;
   logic signed [POS_W-1:0]   cmd_sat;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= '0;
         ki_ff    <= '0;
         kd_ff    <= '0;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_KP:    kp_ff    <= csr_data;
            REG_KI:    ki_ff    <= csr_data;
            REG_KD:    kd_ff    <= csr_data;
            REG_LIMIT: limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign kp_sel  = axis_field(kp_ff, axis_ff);
   assign ki_sel  = axis_field(ki_ff, axis_ff);
   assign kd_sel  = axis_field(kd_ff, axis_ff);
   assign lim_sel = axis_field(limit_ff, axis_ff);

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign req_axis_ok = 32'(req_axis) < AXES;
   assign out_load    = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_axis_ok ? ST_PROP : ST_OUT;
            end
         end
         ST_PROP:  state_in = ST_DERIV;
         ST_DERIV: state_in = ST_CLAMP;
         ST_CLAMP: begin
            if (mode_ff == MODE_PID && ki_sel != '0) begin
               state_in = ST_INTEG;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_INTEG: state_in = ST_ACCUM;
         ST_ACCUM: state_in = ST_KI_LO;
         ST_KI_LO: state_in = ST_KI_HI;
         ST_KI_HI: state_in = ST_SUM;
         ST_SUM:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mac_ctrl = '0;
      op_a     = '0;
      op_b     = '0;
      unique case (state_ff)
         ST_PROP: begin
            mac_ctrl.enable = 1'b1;
            mac_ctrl.clear  = 1'b1;
            op_a = {1'b0, kp_sel};
            op_b = {ep_ff[ERR_W-1], ep_ff};
         end
         ST_DERIV: begin
            mac_ctrl.enable = 1'b1;
            op_a = {1'b0, kd_sel};
            op_b = {ed_ff[ERR_W-1], ed_ff};
         end
         ST_INTEG: begin
            mac_ctrl.enable = 1'b1;
            mac_ctrl.clear  = 1'b1;
            op_a = {1'b0, dt_ff};
            op_b = {ep_ff[ERR_W-1], ep_ff};
         end
         ST_KI_LO: begin
            mac_ctrl.enable = 1'b1;
            mac_ctrl.clear  = 1'b1;
            op_a = {1'b0, ki_sel};
            op_b = {{(OPB_W-HALF_W){1'b0}}, integ_rd[HALF_W-1:0]};
         end
         ST_KI_HI: begin
            mac_ctrl.enable   = 1'b1;
            mac_ctrl.shift_hi = 1'b1;
            op_a = {1'b0, ki_sel};
            op_b = {{(OPB_W-HALF_W){integ_rd[INTEG_W-1]}}, integ_rd[INTEG_W-1:HALF_W]};
         end
         default: ;
      endcase
   end

   pdac_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   // ------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------
   assign lim_pos = {{(ACC_W-GAIN_W-16){1'b0}}, lim_sel, 16'h0000};
   assign lim_neg = -lim_pos;

   always_comb begin
      priority if (acc > lim_pos) begin
         pd_clamped = lim_pos;
      end else if (acc < lim_neg) begin
         pd_clamped = lim_neg;
      end else begin
         pd_clamped = acc;
      end
   end

   // Integral increment is ep*dt in Q16.32, floored to Q32.16.
   assign integ_inc = acc[OPB_W+15:16];
   assign integ_sum = {{2{integ_rd[INTEG_W-1]}}, integ_rd}
                      + {{(INTEG_W+2-OPB_W){integ_inc[OPB_W-1]}}, integ_inc};

   always_comb begin
      if ((&integ_sum[INTEG_W+1:INTEG_W-1]) || !(|integ_sum[INTEG_W+1:INTEG_W-1])) begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end else if (integ_sum[INTEG_W+1]) begin
         integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
      end
   end

   assign cmd_total = {{(ACC_W-7-CMD_W){cmd_ff[CMD_W-1]}}, cmd_ff}
                      + {acc[ACC_W-1], acc[ACC_W-1:8]};

   always_comb begin
      if ((&cmd_total[ACC_W-8:POS_W-1]) || !(|cmd_total[ACC_W-8:POS_W-1])) begin
         cmd_sat = cmd_total[POS_W-1:0];
      end else if (cmd_total[ACC_W-8]) begin
         cmd_sat = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         cmd_sat = {1'b0, {(POS_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_mode;
         axis_ff <= req_axis;
         ep_ff   <= {req_target_position[POS_W-1], req_target_position}
                    - {req_current_position[POS_W-1], req_current_position};
         ed_ff   <= {req_target_velocity[POS_W-1], req_target_velocity}
                    - {req_current_velocity[POS_W-1], req_current_velocity};
         dt_ff   <= req_time_step;
         res_ff  <= '0;
      end
      if (state_ff == ST_CLAMP) begin
         cmd_ff <= pd_clamped[CMD_W+7:8];
         res_ff <= {{(POS_W-CMD_W){pd_clamped[CMD_W+7]}}, pd_clamped[CMD_W+7:8]};
      end
      if (state_ff == ST_SUM) begin
         res_ff <= cmd_sat;
      end
   end

   // ------------------------------------------------------------------
   // Per-axis error integral
   // ------------------------------------------------------------------
   assign integ_idx = IDX_W'(axis_ff);
   assign integ_rd  = integ_ff[integ_idx];

   // A zero I gain in PID mode clears the integral of that axis.
   assign integ_we = (state_ff == ST_ACCUM)
                     || (state_ff == ST_CLAMP && mode_ff == MODE_PID && ki_sel == '0);
   assign integ_in = (state_ff == ST_ACCUM) ? integ_sat : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            integ_ff[i] <= '0;
         end
      end else if (integ_we) begin
         integ_ff[integ_idx] <= integ_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_axis_ff <= axis_ff;
         rsp_cmd_ff  <= res_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_axis      = rsp_axis_ff;
   assign rsp_accel_command = rsp_cmd_ff;

`ifndef SYNTH
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result word appeared without passing the output state");

   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start the sequencer");

   a_pd_keeps_integral: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && mode_ff == MODE_PD && 32'(axis_ff) < AXES)
      |=> $stable(integ_rd))
      else $error("PD word changed the error integral");

   a_sum_only_pid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KI_LO) |-> (mode_ff == MODE_PID && ki_sel != '0))
      else $error("I term computed for a word without an active integrator");
`endif

endmodule

>>> tb/tb.sv
module tb;
   import pdac_pkg::*;

   localparam int NUM_AXES = 3;

   localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
   localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

   localparam csr_index_type REG_UNUSED_FIRST = 3'd4;
   localparam csr_index_type REG_UNUSED_LAST  = 3'd7;

   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;

   localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint INTEG_MIN = -INTEG_MAX - 1;
   localparam longint CMD_MAX   = 64'sd2147483647;
   localparam longint CMD_MIN   = -64'sd2147483648;

   typedef struct packed {
      logic [AXIS_W-1:0] axis;
      logic [POS_W-1:0]  command;
   } accel_word_type;

   // Holds the controller state as software sees it and the commands still owed.
   class accel_command_board;
      logic [REG_W-1:0] gain_p;
      logic [REG_W-1:0] gain_i;
      logic [REG_W-1:0] gain_d;
      logic [REG_W-1:0] accel_limit;
      longint           integral [NUM_AXES];
      accel_word_type   pending_commands [$];
      int               mismatch_count;

      function new();
         gain_p = '0;
         gain_i = '0;
         gain_d = '0;
         accel_limit = LIMIT_RESET;
         foreach (integral[a]) integral[a] = 0;
         mismatch_count = 0;
      endfunction

      function longint lane(logic [REG_W-1:0] word48, logic [AXIS_W-1:0] axis);
         logic [GAIN_W-1:0] part;
         if (axis > AXIS_Z) return 0;
         part = 16'(word48 >> (16 * axis));
         return longint'(part);
      endfunction

      function void write_register(csr_index_type index, logic [REG_W-1:0] value);
         case (index)
            REG_KP:    gain_p = value;
            REG_KI:    gain_i = value;
            REG_KD:    gain_d = value;
            REG_LIMIT: accel_limit = value;
            default: ;
         endcase
      endfunction

      function void note_command(logic mode, logic [AXIS_W-1:0] axis,
                                 logic signed [POS_W-1:0] cur_pos,
                                 logic signed [POS_W-1:0] cur_vel,
                                 logic signed [POS_W-1:0] tgt_pos,
                                 logic signed [POS_W-1:0] tgt_vel,
                                 logic [DT_W-1:0] step_time);
         longint         err_pos, err_vel, kp, ki, kd, lim, pd, cmd, acc;
         accel_word_type want;
         want.axis = axis;
         want.command = '0;
         if (axis >= NUM_AXES) begin
            pending_commands.push_back(want);
            return;
         end
         err_pos = longint'(tgt_pos) - longint'(cur_pos);
         err_vel = longint'(tgt_vel) - longint'(cur_vel);
         kp = lane(gain_p, axis);
         ki = lane(gain_i, axis);
         kd = lane(gain_d, axis);
         lim = lane(accel_limit, axis) * 65536;

         // The PD sum is clamped in Q24.24 before dropping to Q16.16.
         pd = kp * err_pos + kd * err_vel;
         if (pd > lim) pd = lim;
         if (pd < -lim) pd = -lim;
         cmd = pd >>> 8;

         if (mode == MODE_PID) begin
            if (ki != 0) begin
               acc = integral[axis] + ((err_pos * longint'(step_time)) >>> 16);
               if (acc > INTEG_MAX) acc = INTEG_MAX;
               if (acc < INTEG_MIN) acc = INTEG_MIN;
               integral[axis] = acc;
            end else begin
               integral[axis] = 0;
            end
            cmd = cmd + ((ki * integral[axis]) >>> 8);
         end

         if (cmd > CMD_MAX) cmd = CMD_MAX;
         if (cmd < CMD_MIN) cmd = CMD_MIN;
         want.command = cmd[POS_W-1:0];
         pending_commands.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("%0t ERROR: %s", $time, msg);
         mismatch_count++;
      endtask

      task check_command(logic [AXIS_W-1:0] axis, logic [POS_W-1:0] command);
         accel_word_type want;
         if (pending_commands.size() == 0) begin
            report_mismatch($sformatf("unexpected word: axis %0d command %h", axis, command));
            return;
         end
         want = pending_commands.pop_front();
         if (axis !== want.axis)
            report_mismatch($sformatf("axis %0d, expected %0d", axis, want.axis));
         if (command !== want.command)
            report_mismatch($sformatf("axis %0d command %h, expected %h",
                                      want.axis, command, want.command));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_mode = MODE_PID;
   logic [AXIS_W-1:0]        req_axis = AXIS_X;
   logic signed [POS_W-1:0]  req_current_position = '0;
   logic signed [POS_W-1:0]  req_current_velocity = '0;
   logic signed [POS_W-1:0]  req_target_position = '0;
   logic signed [POS_W-1:0]  req_target_velocity = '0;
   logic [DT_W-1:0]          req_time_step = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [AXIS_W-1:0]        rsp_out_axis;
   logic signed [POS_W-1:0]  rsp_accel_command;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   csr_index_type            csr_index = REG_KP;
   logic [REG_W-1:0]         csr_data = '0;

   logic                     idle_enable = 1'b1;
   int                       stall_left = 0;

   accel_command_board board = new();

   position_pid_accel_command_top #(.AXES(NUM_AXES)) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_axis             (req_axis),
      .req_current_position (req_current_position),
      .req_current_velocity (req_current_velocity),
      .req_target_position  (req_target_position),
      .req_target_velocity  (req_target_velocity),
      .req_time_step        (req_time_step),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_axis         (rsp_out_axis),
      .rsp_accel_command    (rsp_accel_command),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("position_pid_accel_command_top: mismatch");
      $finish;
   end

   // Result side: check every accepted word, and stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_command(rsp_out_axis, rsp_accel_command);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_word(logic mode, logic [AXIS_W-1:0] axis,
                            logic signed [POS_W-1:0] cur_pos,
                            logic signed [POS_W-1:0] cur_vel,
                            logic signed [POS_W-1:0] tgt_pos,
                            logic signed [POS_W-1:0] tgt_vel,
                            logic [DT_W-1:0] step_time);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_axis <= axis;
      req_current_position <= cur_pos;
      req_current_velocity <= cur_vel;
      req_target_position <= tgt_pos;
      req_target_velocity <= tgt_vel;
      req_time_step <= step_time;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_command(mode, axis, cur_pos, cur_vel, tgt_pos, tgt_vel, step_time);
   endtask

   // Valid is left high after a word so back-to-back words need no toggling.
   task automatic drain_commands();
      req_valid <= 1'b0;
      while (board.pending_commands.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type index, logic [REG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.write_register(index, value);
   endtask

   task automatic load_settings(logic [REG_W-1:0] kp, logic [REG_W-1:0] ki,
                                logic [REG_W-1:0] kd, logic [REG_W-1:0] lim);
      write_register(REG_KP, kp);
      write_register(REG_KI, ki);
      write_register(REG_KD, kd);
      if ($urandom_range(0, 1) == 0)
         write_register(csr_index_type'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                        REG_W'({$urandom, $urandom}));
      write_register(REG_LIMIT, lim);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [REG_W-1:0] random_gains();
      logic [REG_W-1:0] value;
      logic [GAIN_W-1:0] part;
      value = '0;
      for (int a = 0; a < 3; a++) begin
         case ($urandom_range(0, 5))
            0: part = '0;
            1: part = '1;
            2, 3: part = 16'($urandom_range(0, 16'h0400));
            default: part = 16'($urandom);
         endcase
         value[16*a +: 16] = part;
      end
      return value;
   endfunction

   function automatic logic signed [POS_W-1:0] extreme_value();
      case ($urandom_range(0, 3))
         0: return POS_MIN;
         1: return POS_MAX;
         2: return '0;
         default: return -32'sd1;
      endcase
   endfunction

   // Mostly a small offset from the base, so the error stays in the useful range.
   function automatic logic signed [POS_W-1:0] near(logic signed [POS_W-1:0] base);
      logic signed [POS_W-1:0] delta;
      delta = $urandom_range(0, 32'h0020_0000);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return extreme_value();
         default: return base + delta - 32'sh0010_0000;
      endcase
   endfunction

   task automatic random_words(int count, bit allow_idle);
      logic                    mode;
      logic [AXIS_W-1:0]       axis;
      logic signed [POS_W-1:0] cp, cv;
      logic [DT_W-1:0]         dt;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0)
            idle_enable = allow_idle && ($urandom_range(0, 3) != 0);
         mode = ($urandom_range(0, 9) < 7) ? MODE_PID : MODE_PD;
         axis = ($urandom_range(0, 15) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
         cp = ($urandom_range(0, 7) == 0) ? extreme_value() : $urandom;
         cv = ($urandom_range(0, 7) == 0) ? extreme_value() : $urandom;
         case ($urandom_range(0, 15))
            0: dt = '0;
            1: dt = '1;
            2, 3, 4, 5: dt = 16'($urandom_range(1, 255));
            default: dt = 16'($urandom);
         endcase
         send_word(mode, axis, cp, cv, near(cp), near(cv), dt);
         if ($urandom_range(0, 63) == 0)
            drain_commands();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Values out of reset: no gains, unit limit.
      send_word(MODE_PID, AXIS_X, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 16'hFFFF);
      send_word(MODE_PD, AXIS_Z, 32'sh0001_0000, '0, 32'sh0005_0000, 32'sh0002_0000, 16'h1000);
      send_word(MODE_PID, AXIS_Y, '0, '0, 32'sh0000_8000, '0, 16'h0100);
      drain_commands();

      // Full gains on x, zero I gain on y, zero limit on z.
      load_settings(48'h0200_0100_FFFF, 48'h0010_0000_FFFF, 48'h0300_0080_FFFF,
                    48'h0000_0100_FFFF);
      send_word(MODE_PID, AXIS_X, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 16'hFFFF);
      send_word(MODE_PID, AXIS_X, POS_MAX, POS_MIN, POS_MIN, POS_MAX, 16'hFFFF);
      send_word(MODE_PID, AXIS_X, POS_MAX, POS_MIN, POS_MIN, POS_MAX, 16'hFFFF);
      send_word(MODE_PD, AXIS_X, POS_MIN, '0, POS_MAX, '0, 16'h0001);
      send_word(MODE_PD, AXIS_X, POS_MAX, '0, POS_MIN, '0, 16'h0001);
      send_word(MODE_PID, AXIS_X, 32'sh0001_0000, 32'sh0000_1000, 32'sh0001_0000,
                32'sh0000_1000, 16'hFFFF);
      send_word(MODE_PID, AXIS_Y, 32'sh0003_0000, '0, 32'sh0001_8000, 32'sh0000_4000,
                16'h8000);
      send_word(MODE_PD, AXIS_Y, '0, '0, -32'sd3, -32'sd5, 16'h0010);
      send_word(MODE_PID, AXIS_Z, '0, '0, 32'sh0010_0000, 32'sh0001_0000, 16'h0000);
      send_word(MODE_PID, AXIS_Z, 32'sh0010_0000, '0, '0, '0, 16'h0001);
      send_word(MODE_PID, AXIS_Z, -32'sd7, '0, 32'sd9, '0, 16'hFFFF);
      send_word(MODE_PD, AXIS_Z, POS_MIN, POS_MIN, POS_MAX, POS_MAX, 16'h4000);
      send_word(MODE_PID, AXIS_NONE, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 16'hFFFF);
      send_word(MODE_PD, AXIS_NONE, 32'sh0000_1234, '0, '0, '0, 16'h0001);
      drain_commands();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_settings('1, '1, '1, '1);
            1: load_settings(random_gains(), '0, random_gains(), random_gains());
            default: load_settings(random_gains(), random_gains(), random_gains(),
                                   random_gains());
         endcase
         random_words(142, phase != 5);
         drain_commands();
      end

      repeat (24) @(posedge clock);
      if (board.pending_commands.size() != 0)
         board.report_mismatch($sformatf("%0d commands never arrived",
                                         board.pending_commands.size()));
      if (board.mismatch_count == 0)
         $display("position_pid_accel_command_top: match");
      else
         $display("position_pid_accel_command_top: mismatch");
      $finish;
   end

endmodule

>>> sim.f
src/pdac_pkg.sv
src/pdac_mac.sv
src/position_pid_accel_command_top.sv
tb/tb.sv
